// ===== sv/tbrl_pkg.sv =====
// Package for the token bucket rate limiter.
// Holds shared widths, reset values and configuration register indexes.
// No dependencies.
package tbrl_pkg;

    // Default parameter values
    localparam int TOKEN_BITS_DEF = 16;
    localparam int TIME_BITS_DEF  = 48;

    // Fixed field widths
    localparam int PERIOD_BITS  = 40;
    localparam int RESV_BITS    = 16;
    localparam int CFG_IDX_BITS = 2;

    // Register reset values
    localparam int                     CAP_RESET    = 16;
    localparam logic [RESV_BITS-1:0]   RESV_RESET   = '0;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 40'd1000000;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_CAPACITY      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RESERVED_EXIT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_REFILL_PERIOD = 2'd2;

endpackage

// ===== sv/tbrl_div.sv =====
// Iterative restoring divider: one quotient bit per cycle.
// Divides a TIME_BITS elapsed time by the 40-bit refill period.
// Depends on tbrl_pkg.
module tbrl_div #(
    parameter int TIME_BITS = tbrl_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [TIME_BITS-1:0]             dividend,
    input  logic [tbrl_pkg::PERIOD_BITS-1:0] divisor,
    output logic                             done,
    output logic [TIME_BITS-1:0]             quotient,
    output logic [tbrl_pkg::PERIOD_BITS-1:0] remainder
);
    import tbrl_pkg::*;

    localparam int CNT_W = $clog2(TIME_BITS);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [TIME_BITS-1:0]   quo_reg, quo_next;
    logic [PERIOD_BITS-1:0] rem_reg, rem_next;
    logic [PERIOD_BITS-1:0] dvs_reg, dvs_next;

    logic [PERIOD_BITS:0]   trial;
    logic [PERIOD_BITS:0]   diff;
    logic                   fits;

    // Shared subtract/compare step
    assign trial = {rem_reg, quo_reg[TIME_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    // Step control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(TIME_BITS - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[TIME_BITS-2:0], fits};
            rem_next = fits ? diff[PERIOD_BITS-1:0] : trial[PERIOD_BITS-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== sv/token_bucket_rate_limiter.sv =====
// Two-lane token bucket. A request passes IDLE, PREP, DIV, APPLY and GRANT; in DIV the
// bit-serial divider computes whole refill periods. DIV is skipped when refill is
// skipped (period zero or time not advanced). GRANT waits for the output slot to free.
// A new request is taken only in IDLE, after the last one has left GRANT. The
// result sits in an output register, so a new request may be taken while it waits.
// Reset: capacity 16, tokens full, reserve 0, period 1000000, stamp 0; no clearing pass.
module token_bucket_rate_limiter #(
    parameter int TOKEN_BITS = tbrl_pkg::TOKEN_BITS_DEF,
    parameter int TIME_BITS  = tbrl_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic                              is_exit,
    input  logic [TIME_BITS-1:0]              now,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              granted,
    output logic [TOKEN_BITS-1:0]             avail,
    // configuration channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tbrl_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [tbrl_pkg::PERIOD_BITS-1:0]  cfg_data
);
    import tbrl_pkg::*;

    localparam int CW = (TOKEN_BITS > RESV_BITS) ? TOKEN_BITS : RESV_BITS;
    localparam int MW = (TOKEN_BITS > TIME_BITS) ? TOKEN_BITS : TIME_BITS;
    localparam int EW = (TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_APPLY = 3'd3;
    localparam logic [2:0] ST_GRANT = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic                   kind_reg, kind_next;
    logic                   exit_reg, exit_next;
    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic                   skip_reg, skip_next;
    logic [TOKEN_BITS-1:0]  cap_reg, cap_next;
    logic [RESV_BITS-1:0]   resv_reg, resv_next;
    logic [PERIOD_BITS-1:0] period_reg, period_next;
    logic [TOKEN_BITS-1:0]  tokens_reg, tokens_next;
    logic [TIME_BITS-1:0]   stamp_reg, stamp_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   granted_reg, granted_next;
    logic [TOKEN_BITS-1:0]  avail_reg, avail_next;

    logic                   div_start;
    logic                   div_done;
    logic [TIME_BITS-1:0]   div_quo;
    logic [PERIOD_BITS-1:0] div_rem;

    logic [TOKEN_BITS-1:0]  headroom;
    logic [TOKEN_BITS-1:0]  credit;
    logic [TOKEN_BITS-1:0]  floor_v;
    logic [TOKEN_BITS-1:0]  tokens_after;
    logic                   take;
    logic                   slot_free;

    tbrl_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (now_reg - stamp_reg),
        .divisor   (period_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Credit: whole periods, capped by room left in the bucket
    assign headroom = cap_reg - tokens_reg;
    assign credit   = (MW'(div_quo) < MW'(headroom)) ? TOKEN_BITS'(div_quo) : headroom;

    // Lane floor: reserve clamped to capacity, zero on the exit lane
    always_comb
    begin
        if (exit_reg)
            floor_v = '0;
        else if (CW'(resv_reg) > CW'(cap_reg))
            floor_v = cap_reg;
        else
            floor_v = TOKEN_BITS'(resv_reg);
    end

    assign take         = !kind_reg && (tokens_reg > floor_v);
    assign tokens_after = tokens_reg - TOKEN_BITS'(take);
    assign slot_free    = !out_valid_reg || out_ready;

    // Sequencer and bucket state
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        exit_next      = exit_reg;
        now_next       = now_reg;
        skip_next      = skip_reg;
        cap_next       = cap_reg;
        resv_next      = resv_reg;
        period_next    = period_reg;
        tokens_next    = tokens_reg;
        stamp_next     = stamp_reg;
        out_valid_next = out_valid_reg;
        granted_next   = granted_reg;
        avail_next     = avail_reg;
        div_start      = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind;
                    exit_next  = is_exit;
                    now_next   = now;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                skip_next = (period_reg == '0) || (now_reg <= stamp_reg);
                if ((period_reg == '0) || (now_reg <= stamp_reg))
                    state_next = ST_APPLY;
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                // stamp moves to now minus the leftover partial period
                if (!skip_reg && (div_quo != '0))
                begin
                    tokens_next = tokens_reg + credit;
                    stamp_next  = TIME_BITS'(EW'(now_reg) - EW'(div_rem));
                end
                state_next = ST_GRANT;
            end
            ST_GRANT:
            begin
                if (slot_free)
                begin
                    tokens_next    = tokens_after;
                    granted_next   = take;
                    avail_next     = (tokens_after > floor_v) ? tokens_after - floor_v : '0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Configuration writes (only while idle)
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CAPACITY:
                begin
                    cap_next    = TOKEN_BITS'(cfg_data[RESV_BITS-1:0]);
                    tokens_next = TOKEN_BITS'(cfg_data[RESV_BITS-1:0]);
                end
                REG_RESERVED_EXIT:
                begin
                    resv_next = cfg_data[RESV_BITS-1:0];
                end
                REG_REFILL_PERIOD:
                begin
                    period_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control and bucket registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= TOKEN_BITS'(CAP_RESET);
            resv_reg      <= RESV_RESET;
            period_reg    <= PERIOD_RESET;
            tokens_reg    <= TOKEN_BITS'(CAP_RESET);
            stamp_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            resv_reg      <= resv_next;
            period_reg    <= period_next;
            tokens_reg    <= tokens_next;
            stamp_reg     <= stamp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        exit_reg    <= exit_next;
        now_reg     <= now_next;
        skip_reg    <= skip_next;
        granted_reg <= granted_next;
        avail_reg   <= avail_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign granted   = granted_reg;
    assign avail     = avail_reg;

endmodule
